FILE: hdl/tssp_pkg.sv
// ----------------------------------------------------------------------------
// tssp_pkg: shared types and codes of the timed setpoint segment player
// Commands, status codes, register indexes, table entry and config records.
// ----------------------------------------------------------------------------
package tssp_pkg;

    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR        = 2'd0,
        CMD_LOAD         = 2'd1,
        CMD_RESET_CURSOR = 2'd2,
        CMD_LOOKUP       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_CLAMP = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    localparam logic [CFG_ADDR_W-1:0] REG_END_POLICY   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AIRSPEED_MIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AIRSPEED_MAX = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LAT_ACCEL    = 2'd3;

    localparam logic [1:0] END_HOLD_LAST = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CMP,
        ST_LU_RD,
        ST_LU_STOP,
        ST_LU_START,
        ST_LU_VAL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [15:0] lateral_accel;
        logic signed [15:0] climb_rate;
        logic signed [15:0] airspeed;
    } seg_vals_t;

    typedef struct packed {
        logic signed [31:0] start;
        logic signed [31:0] stop;
        seg_vals_t          vals;
    } seg_entry_t;

    typedef struct packed {
        logic [1:0]         tail_mode;
        logic signed [15:0] spd_floor;
        logic signed [15:0] spd_ceil;
        logic [14:0]        lat_limit;
    } cfg_t;

endpackage

FILE: hdl/tssp_clamp.sv
// ----------------------------------------------------------------------------
// tssp_clamp: load value limiter
// Limit airspeed to the configured band and lateral acceleration to +-limit.
// ----------------------------------------------------------------------------
module tssp_clamp
(
    input  tssp_pkg::cfg_t     cfg,
    input  logic signed [15:0] airspeed_in,
    input  logic signed [15:0] lat_in,
    output logic signed [15:0] airspeed_out,
    output logic signed [15:0] lat_out,
    output logic               clamped
);
    import tssp_pkg::*;

    logic signed [15:0] v_lo;
    logic signed [16:0] lim;
    logic signed [16:0] lim_neg;
    logic signed [16:0] a_ext;
    logic signed [16:0] a_hi;
    logic signed [16:0] a_lo;

    // lower bound first, then upper bound: the upper one wins if inverted
    assign v_lo         = (airspeed_in < cfg.spd_floor) ? cfg.spd_floor : airspeed_in;
    assign airspeed_out = (v_lo > cfg.spd_ceil) ? cfg.spd_ceil : v_lo;

    assign lim     = $signed({2'b00, cfg.lat_limit});
    assign lim_neg = -lim;
    assign a_ext   = 17'(lat_in);
    assign a_hi    = (a_ext > lim) ? lim : a_ext;
    assign a_lo    = (a_hi < lim_neg) ? lim_neg : a_hi;
    assign lat_out = a_lo[15:0];

    assign clamped = (airspeed_out != airspeed_in) || (a_lo != a_ext);

endmodule

FILE: hdl/time_segment_setpoint_player_top.sv
// ----------------------------------------------------------------------------
// time_segment_setpoint_player_top: timed setpoint segment table and player
// Sorted insertion of segments, cursor-based lookup with gap, start and end
// handling, one shared signed time comparator under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  --------------------------------
//  s_axis    in         tvalid / tready           tdata: times and values, tuser: cmd
//  m_axis    out        tvalid / tready           tdata: setpoint, tuser: flags
//  cfg       in         cfg_we (no wait)          cfg_addr, cfg_wdata
//
//  Clear and cursor reset go straight to ST_FIN after the transfer. A load
//  reads and compares the entries below the free place in turn, moving each
//  later start up by one place, then writes the new segment; a lookup on an
//  empty table goes straight to ST_FIN, otherwise it checks the stop time of
//  each segment the cursor passes and the start time of the one it stops at.
//  A full output register holds the sequencer in ST_FIN.
//  Reset clears count, cursor, config and handshake state; the table itself
//  is left as it is and needs no clearing pass. While a result waits in the
//  output register for the sink, the input side can still take one command.
//
module time_segment_setpoint_player_top
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // cfg
    input  logic                               cfg_we,
    input  logic [tssp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tssp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: seg_start[31:0], seg_end[31:0], seg_airspeed[15:0],
    //                   seg_climb_rate[15:0], seg_lateral_accel[15:0], query_time[31:0]
    input  logic [tssp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [tssp_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: airspeed_cmd[15:0], climb_rate_cmd[15:0], lateral_accel_cmd[15:0]
    output logic [tssp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser from bit 0: use_cruise, status[1:0]
    output logic [tssp_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import tssp_pkg::*;

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // configuration
    cfg_t cfg_reg;

    // sequencer state
    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        cursor_reg, cursor_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic signed [31:0]   tkey_reg, tkey_next;
    seg_entry_t           new_reg, new_next;
    seg_vals_t            res_vals_reg, res_vals_next;
    logic                 res_cruise_reg, res_cruise_next;
    status_t              res_status_reg, res_status_next;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0]   m_user_reg, m_user_next;

    // table memory, one write and one registered read port
    seg_entry_t           table_mem [MAX_SEGMENTS];
    seg_entry_t           rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    seg_entry_t           wr_data;

    // shared comparator: captured time against a stored time
    logic signed [31:0]   cmp_b;
    logic                 cmp_sel_stop;
    logic                 cmp_lt;

    logic [CW-1:0]        pos_m1;
    logic [CW-1:0]        cur_m1;
    logic [CW-1:0]        cnt_m1;
    logic [CW-1:0]        cur_p1;
    logic [CW-1:0]        cnt_p1;

    // input unpacking and load clamp
    cmd_t                 in_cmd;
    logic signed [31:0]   in_start;
    logic signed [31:0]   in_end;
    logic signed [15:0]   in_airspeed;
    logic signed [15:0]   in_climb;
    logic signed [15:0]   in_lat;
    logic signed [31:0]   in_query;
    logic signed [15:0]   cl_airspeed;
    logic signed [15:0]   cl_lat;
    logic                 cl_flag;
    logic                 in_xfer;

    assign in_cmd      = cmd_t'(s_axis_tuser);
    assign in_start    = s_axis_tdata[31:0];
    assign in_end      = s_axis_tdata[63:32];
    assign in_airspeed = s_axis_tdata[79:64];
    assign in_climb    = s_axis_tdata[95:80];
    assign in_lat      = s_axis_tdata[111:96];
    assign in_query    = s_axis_tdata[143:112];

    tssp_clamp u_clamp
    (
        .cfg          (cfg_reg),
        .airspeed_in  (in_airspeed),
        .lat_in       (in_lat),
        .airspeed_out (cl_airspeed),
        .lat_out      (cl_lat),
        .clamped      (cl_flag)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign pos_m1 = pos_reg - CW'(1);
    assign cur_m1 = cursor_reg - CW'(1);
    assign cnt_m1 = count_reg - CW'(1);
    assign cur_p1 = cursor_reg + CW'(1);
    assign cnt_p1 = count_reg + CW'(1);

    assign cmp_b  = cmp_sel_stop ? rd_data_reg.stop : rd_data_reg.start;
    assign cmp_lt = (tkey_reg < cmp_b);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tail_mode <= END_HOLD_LAST;
            cfg_reg.spd_floor <= 16'sd2560;
            cfg_reg.spd_ceil  <= 16'sd7680;
            cfg_reg.lat_limit <= 15'd2560;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_END_POLICY:   cfg_reg.tail_mode <= cfg_wdata[1:0];
                REG_AIRSPEED_MIN: cfg_reg.spd_floor <= cfg_wdata;
                REG_AIRSPEED_MAX: cfg_reg.spd_ceil  <= cfg_wdata;
                REG_LAT_ACCEL:    cfg_reg.lat_limit <= cfg_wdata[14:0];
            endcase
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        tkey_reg       <= tkey_next;
        new_reg        <= new_next;
        res_vals_reg   <= res_vals_next;
        res_cruise_reg <= res_cruise_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        pos_next        = pos_reg;
        tkey_next       = tkey_reg;
        new_next        = new_reg;
        res_vals_next   = res_vals_reg;
        res_cruise_next = res_cruise_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        rd_en           = 1'b0;
        rd_addr         = cursor_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = pos_reg[AW-1:0];
        wr_data         = new_reg;
        cmp_sel_stop    = 1'b0;

        // drop the result once the sink takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_vals_next   = '0;
                    res_cruise_next = 1'b0;
                    res_status_next = STAT_OK;
                    new_next.start  = in_start;
                    new_next.stop   = in_end;
                    new_next.vals.airspeed      = cl_airspeed;
                    new_next.vals.climb_rate    = in_climb;
                    new_next.vals.lateral_accel = cl_lat;
                    state_next      = ST_FIN;
                    unique case (in_cmd)
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        CMD_RESET_CURSOR:
                        begin
                            cursor_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            tkey_next = in_start;
                            if (count_reg == CW'(MAX_SEGMENTS))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                res_status_next = cl_flag ? STAT_CLAMP : STAT_OK;
                                pos_next        = count_reg;
                                state_next      = ST_LD_RD;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            tkey_next = in_query;
                            if (count_reg == '0)
                            begin
                                res_cruise_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LU_RD;
                            end
                        end
                    endcase
                end
            end

            ST_LD_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = cnt_p1;
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_m1[AW-1:0];
                    state_next = ST_LD_CMP;
                end
            end

            ST_LD_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_lt)
                begin
                    // stored start later than new start: move it up one place
                    wr_data    = rd_data_reg;
                    pos_next   = pos_m1;
                    state_next = ST_LD_RD;
                end
                else
                begin
                    count_next = cnt_p1;
                    state_next = ST_FIN;
                end
            end

            ST_LU_RD:
            begin
                if (cursor_reg >= count_reg)
                begin
                    if (cfg_reg.tail_mode != END_HOLD_LAST)
                    begin
                        res_cruise_next = 1'b1;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cnt_m1[AW-1:0];
                        state_next = ST_LU_VAL;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cursor_reg[AW-1:0];
                    state_next = ST_LU_STOP;
                end
            end

            ST_LU_STOP:
            begin
                cmp_sel_stop = 1'b1;
                if (!cmp_lt)
                begin
                    // segment over: advance the cursor
                    cursor_next = cur_p1;
                    state_next  = ST_LU_RD;
                end
                else
                begin
                    state_next = ST_LU_START;
                end
            end

            ST_LU_START:
            begin
                if (cmp_lt)
                begin
                    if (cursor_reg == '0)
                    begin
                        res_cruise_next = 1'b1;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        // in a gap: hold the previous segment
                        rd_en      = 1'b1;
                        rd_addr    = cur_m1[AW-1:0];
                        state_next = ST_LU_VAL;
                    end
                end
                else
                begin
                    res_vals_next = rd_data_reg.vals;
                    state_next    = ST_FIN;
                end
            end

            ST_LU_VAL:
            begin
                res_vals_next = rd_data_reg.vals;
                state_next    = ST_FIN;
            end

            ST_FIN:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_vals_reg.lateral_accel,
                                    res_vals_reg.climb_rate,
                                    res_vals_reg.airspeed};
                    m_user_next  = {res_status_reg, res_cruise_reg};
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cursor_in_table : assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond segment count");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    a_busy_after_xfer : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready again right after a transfer");

    a_full_no_grow : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD)
        && (count_reg == CW'(MAX_SEGMENTS)) |=> (count_reg == CW'(MAX_SEGMENTS)))
        else $error("load into full table changed the count");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the timed setpoint segment player
// Drives commands on the input stream and predicts every result with a
// behavioural table and cursor model. Each result is compared field by field
// across phases with different limits, end policies and handshake pressure.
// ----------------------------------------------------------------------------
module tb;

    import tssp_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 112;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 600000;

    // One input command, fields as they sit on the bus
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [15:0] spd;
        logic [15:0] climb;
        logic [15:0] lat;
        logic [31:0] q;
    } stim_t;

    // One directed row: a command plus, where obvious, its expected flags
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [15:0] spd;
        logic [15:0] climb;
        logic [15:0] lat;
        logic [31:0] q;
        logic        typed;
        logic        want_cruise;
        status_t     want_status;
    } dir_row_t;

    // One expected setpoint result
    typedef struct packed {
        logic [15:0] spd;
        logic [15:0] climb;
        logic [15:0] lat;
        logic        cruise;
        status_t     status;
    } setpoint_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // Shadow of the segment table, cursor and limits
    int          tbl_start [TABLE_DEPTH];
    int          tbl_stop  [TABLE_DEPTH];
    logic [15:0] tbl_spd   [TABLE_DEPTH];
    logic [15:0] tbl_climb [TABLE_DEPTH];
    logic [15:0] tbl_lat   [TABLE_DEPTH];
    int          seg_count  = 0;
    int          cursor_pos = 0;
    logic [1:0]  policy     = END_HOLD_LAST;
    int          spd_lo     = 2560;
    int          spd_hi     = 7680;
    int          lat_lim    = 2560;

    setpoint_t due_setpoints [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_fallback     = 0;
    int n_clamp        = 0;
    int n_full         = 0;

    // Directed rows: cmd, start, end, airspeed, climb, lateral, query,
    // typed expectation, expected cruise flag, expected status
    dir_row_t dir_rows [0:24] = '{
        // lookup on an empty table falls back
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, STAT_OK},
        '{CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          32'hFFFF_FFFF, 1'b1, 1'b0, STAT_OK},
        '{CMD_RESET_CURSOR, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555,
          32'hAAAA_AAAA, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOAD, 100, 200, 5000, -16'sd300, 1000, 32'h7FFF_FFFF, 1'b1, 1'b0, STAT_OK},
        // airspeed below the floor, lateral below the negative limit
        '{CMD_LOAD, 300, 400, 100, 16'sh7FFF, 16'sh8000, 0, 1'b1, 1'b0, STAT_CLAMP},
        // earliest possible start, airspeed above the ceiling
        '{CMD_LOAD, 32'sh8000_0000, -32'sd2147483000, 16'sh7FFF, 0, 0, 0,
          1'b1, 1'b0, STAT_CLAMP},
        // same start as an existing segment, lateral right at the limit
        '{CMD_LOAD, 300, 350, 6000, 16'sh8000, 2560, 0, 1'b1, 1'b0, STAT_OK},
        // end before start, values on the limits
        '{CMD_LOAD, 500, 450, 2560, 16'sh8000, -16'sd2560, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOAD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7680, 1, 0, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_RESET_CURSOR, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 32'sh8000_0000, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 50, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 150, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 250, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 360, 1'b0, 1'b0, STAT_OK},
        // query goes back in time; cursor must stay put
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 100, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 460, 1'b0, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1'b0, 1'b0, STAT_OK},
        '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOAD, 1000, 2000, 4000, 256, -16'sd512, 0, 1'b1, 1'b0, STAT_OK},
        // before the first segment
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 999, 1'b1, 1'b1, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 5000, 1'b0, 1'b0, STAT_OK},
        // clear must also pull the cursor back to the start
        '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOAD, 0, 10, 3000, -16'sd256, 512, 0, 1'b1, 1'b0, STAT_OK},
        '{CMD_LOOKUP, 0, 0, 0, 0, 0, 5, 1'b0, 1'b0, STAT_OK}
    };

    time_segment_setpoint_player_top #(
        .MAX_SEGMENTS (TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Setpoint prediction: apply one command to the shadow table and
    // return the result the block owes for it.
    // ------------------------------------------------------------------
    function automatic setpoint_t play_command(input stim_t s);
        setpoint_t r;
        int        st;
        int        q;
        int        spd;
        int        lat;
        int        spd_in;
        int        lat_in;
        int        pos;
        int        idx;
        r = '0;
        case (s.cmd)
            CMD_CLEAR:
            begin
                seg_count  = 0;
                cursor_pos = 0;
            end
            CMD_RESET_CURSOR:
            begin
                cursor_pos = 0;
            end
            CMD_LOAD:
            begin
                if (seg_count >= TABLE_DEPTH)
                begin
                    // table full: drop the segment, nothing is clamped
                    r.status = STAT_FULL;
                    n_full++;
                end
                else
                begin
                    st     = s.t0;
                    spd_in = $signed(s.spd);
                    lat_in = $signed(s.lat);
                    spd    = spd_in;
                    lat    = lat_in;
                    // floor first, then ceiling: an inverted pair ends on the ceiling
                    if (spd < spd_lo) spd = spd_lo;
                    if (spd > spd_hi) spd = spd_hi;
                    if (lat > lat_lim) lat = lat_lim;
                    if (lat < -lat_lim) lat = -lat_lim;
                    // walk down, moving later starts up; equal starts stay ahead
                    pos = seg_count;
                    while (pos > 0 && tbl_start[pos-1] > st)
                    begin
                        tbl_start[pos] = tbl_start[pos-1];
                        tbl_stop[pos]  = tbl_stop[pos-1];
                        tbl_spd[pos]   = tbl_spd[pos-1];
                        tbl_climb[pos] = tbl_climb[pos-1];
                        tbl_lat[pos]   = tbl_lat[pos-1];
                        pos--;
                    end
                    tbl_start[pos] = st;
                    tbl_stop[pos]  = s.t1;
                    tbl_spd[pos]   = spd[15:0];
                    tbl_climb[pos] = s.climb;
                    tbl_lat[pos]   = lat[15:0];
                    seg_count++;
                    if (spd != spd_in || lat != lat_in)
                    begin
                        r.status = STAT_CLAMP;
                        n_clamp++;
                    end
                end
            end
            default:
            begin
                q   = s.q;
                idx = -1;
                if (seg_count != 0)
                begin
                    while (cursor_pos < seg_count && q >= tbl_stop[cursor_pos])
                        cursor_pos++;
                    if (cursor_pos >= seg_count)
                        idx = (policy == END_HOLD_LAST) ? seg_count - 1 : -1;
                    else if (q < tbl_start[cursor_pos])
                        idx = cursor_pos - 1;   // gap, or -1 before the first
                    else
                        idx = cursor_pos;
                end
                if (idx < 0)
                begin
                    r.cruise = 1'b1;
                    n_fallback++;
                end
                else
                begin
                    r.spd   = tbl_spd[idx];
                    r.climb = tbl_climb[idx];
                    r.lat   = tbl_lat[idx];
                end
            end
        endcase
        return r;
    endfunction

    function automatic longint pick(input int unsigned lo, input int unsigned hi);
        return $urandom_range(hi, lo);
    endfunction

    // Saturate a planning time into the 32-bit millisecond range
    function automatic logic [31:0] clip_ms(input longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Command with every payload field random; callers overwrite what matters
    function automatic stim_t rand_stim(input cmd_t c);
        stim_t s;
        s.cmd   = c;
        s.t0    = $urandom;
        s.t1    = $urandom;
        s.spd   = 16'($urandom);
        s.climb = 16'($urandom);
        s.lat   = 16'($urandom);
        s.q     = $urandom;
        return s;
    endfunction

    // Airspeed aimed at the limits and the band between them
    function automatic logic [15:0] airspeed_sample();
        int v;
        case (pick(0, 3))
            0: v = $urandom;
            1: v = spd_lo + int'(pick(0, 8)) - 4;
            2: v = spd_hi + int'(pick(0, 8)) - 4;
            default: v = (spd_lo <= spd_hi) ? spd_lo + int'(pick(0, spd_hi - spd_lo))
                                            : int'($urandom);
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] lateral_sample();
        int v;
        case (pick(0, 3))
            0: v = $urandom;
            1: v = lat_lim + int'(pick(0, 8)) - 4;
            2: v = -lat_lim + int'(pick(0, 8)) - 4;
            default: v = int'(pick(0, 2 * lat_lim)) - lat_lim;
        endcase
        return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Input side: hold the transfer until the block takes it, then log
    // the predicted result. Idle gaps are rolled cycle by cycle.
    // ------------------------------------------------------------------
    task automatic offer(input stim_t s, input bit typed = 1'b0,
                         input logic want_cruise = 1'b0, input status_t want_status = STAT_OK);
        setpoint_t due;
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = s.cmd;
        s_tdata  = {s.q, s.lat, s.climb, s.spd, s.t1, s.t0};
        do
            @(posedge clk);
        while (!s_tready);
        due = play_command(s);
        // obvious rows carry their expectation in the table itself
        if (typed)
            due = '{spd: '0, climb: '0, lat: '0, cruise: want_cruise, status: want_status};
        due_setpoints.insert(due_setpoints.size(), due);
        n_items++;
        @(negedge clk);
    endtask

    // Wait until every transfer has its result, then let the block settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (due_setpoints.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val[15:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_END_POLICY:   policy  = val[1:0];
            REG_AIRSPEED_MIN: spd_lo  = $signed(val[15:0]);
            REG_AIRSPEED_MAX: spd_hi  = $signed(val[15:0]);
            default:          lat_lim = val & 32'h7FFF;
        endcase
    endtask

    task automatic write_limits(input int pol, input int lo, input int hi, input int lat);
        write_reg(REG_END_POLICY, pol);
        write_reg(REG_AIRSPEED_MIN, lo);
        write_reg(REG_AIRSPEED_MAX, hi);
        write_reg(REG_LAT_ACCEL, lat);
    endtask

    // ------------------------------------------------------------------
    // One well-formed flight plan: clear, load segments in some order,
    // rewind the cursor, then sweep forward with lookups. Small upsets
    // (time stepping back, mid-sweep rewinds) are mixed in.
    // ------------------------------------------------------------------
    task automatic run_program(input bit big);
        int     n;
        int     m;
        int     i;
        int     j;
        longint cur;
        longint st;
        longint en;
        longint prev_st;
        longint first_t;
        longint q;
        longint avg;
        stim_t  plan [0:69];
        stim_t  s;
        stim_t  tmp;
        n = (big || pick(0, 11) == 0) ? int'(pick(62, 70)) : int'(pick(1, 8));
        case (pick(0, 3))
            0: cur = -64'sd2147483648 + pick(0, 2000);
            1: cur = 64'sd2147483647 - pick(0, 20000);
            default: cur = longint'(int'($urandom)) / 2;
        endcase
        prev_st = cur;
        first_t = cur;
        for (i = 0; i < n; i++)
        begin
            s = rand_stim(CMD_LOAD);
            if (i > 0 && pick(0, 7) == 0)
                st = prev_st;
            else
                st = cur + ((pick(0, 2) == 0) ? 0 : pick(0, 400));
            if (pick(0, 19) == 0)
                en = st - pick(1, 300);
            else
                en = st + pick(1, 800);
            if (i == 0) first_t = st;
            s.t0  = clip_ms(st);
            s.t1  = clip_ms(en);
            s.spd = airspeed_sample();
            s.lat = lateral_sample();
            plan[i] = s;
            prev_st = st;
            if (st > cur) cur = st;
            if (en > cur) cur = en;
        end
        // load order: sorted, shuffled or reversed (worst case for insertion)
        case (pick(0, 2))
            0: ;
            1:
            begin
                for (i = n - 1; i > 0; i--)
                begin
                    j       = int'(pick(0, i));
                    tmp     = plan[i];
                    plan[i] = plan[j];
                    plan[j] = tmp;
                end
            end
            default:
            begin
                for (i = 0; i < n / 2; i++)
                begin
                    tmp             = plan[i];
                    plan[i]         = plan[n - 1 - i];
                    plan[n - 1 - i] = tmp;
                end
            end
        endcase
        offer(rand_stim(CMD_CLEAR));
        for (i = 0; i < n; i++)
            offer(plan[i]);
        offer(rand_stim(CMD_RESET_CURSOR));
        m = 2 * n + int'(pick(0, 4));
        if (m > 40) m = 40;
        avg = (cur - first_t + 600) / m + 1;
        if (avg > 1000000000) avg = 1000000000;
        q = first_t - pick(0, 300);
        for (i = 0; i < m; i++)
        begin
            case (pick(0, 19))
                0: q = q - pick(0, 500);
                1:
                begin
                    offer(rand_stim(CMD_RESET_CURSOR));
                    q = first_t - pick(0, 100);
                end
                2:
                begin
                    // land exactly on an end time
                    j = int'(pick(0, n - 1));
                    if (longint'($signed(plan[j].t1)) > q) q = $signed(plan[j].t1);
                end
                default: q = q + pick(0, 32'(2 * avg));
            endcase
            s   = rand_stim(CMD_LOOKUP);
            s.q = clip_ms(q);
            offer(s);
        end
        if (pick(0, 1) == 0)
        begin
            s   = rand_stim(CMD_LOOKUP);
            s.q = clip_ms(cur + pick(0, 5000));
            offer(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: stall at the phase rate, and on request hold off for
    // a long stretch so that the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        setpoint_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_setpoints.size() == 0)
            begin
                $error("result with nothing pending: tdata %h tuser %h", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = due_setpoints.pop_front();
                n_results++;
                if (m_tdata[15:0] !== want.spd)
                begin
                    $error("airspeed_cmd: expected %0d, got %0d",
                           $signed(want.spd), $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[31:16] !== want.climb)
                begin
                    $error("climb_rate_cmd: expected %0d, got %0d",
                           $signed(want.climb), $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tdata[47:32] !== want.lat)
                begin
                    $error("lateral_accel_cmd: expected %0d, got %0d",
                           $signed(want.lat), $signed(m_tdata[47:32]));
                    fail_count++;
                end
                if (m_tuser[0] !== want.cruise)
                begin
                    $error("use_cruise: expected %0d, got %0d", want.cruise, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[2:1] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: drop out if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed rows, then random phases. Limits are
    // rewritten only between phases, once the block has drained.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int ph;
        int i;
        int k;
        int start_items;
        int lo;
        int hi;
        int tmp;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1: write_limits(1, -32768, 32767, 32767);
                    2: write_limits(2, 32767, -32768, 0);     // inverted pair, no lateral
                    3: write_limits(3, 0, 0, 1);
                    default:
                    begin
                        lo = int'(pick(0, 12000)) - 2000;
                        hi = lo + int'(pick(0, 8000));
                        if (pick(0, 3) == 0)
                        begin
                            tmp = lo;
                            lo  = hi;
                            hi  = tmp;
                        end
                        write_limits(ph - 4, lo, hi,
                                     (pick(0, 1) == 0) ? int'(pick(0, 4000))
                                                       : int'(pick(0, 32767)));
                    end
                endcase
            end
            // handshake mix: none, sender gaps, receiver stalls, both
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            start_items = n_items;
            if (ph == 0)
            begin
                for (i = 0; i < 25; i++)
                    offer(stim_t'({dir_rows[i].cmd, dir_rows[i].t0, dir_rows[i].t1,
                                   dir_rows[i].spd, dir_rows[i].climb, dir_rows[i].lat,
                                   dir_rows[i].q}),
                          dir_rows[i].typed, dir_rows[i].want_cruise,
                          dir_rows[i].want_status);
            end
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == 3 || ph == 6)
                run_program(1'b1);
            while (n_items - start_items < PHASE_ITEMS)
            begin
                if (pick(0, 99) < 15)
                begin
                    // noise: short burst of arbitrary commands
                    for (k = int'(pick(1, 4)); k > 0; k--)
                        offer(rand_stim(cmd_t'(pick(0, 3))));
                end
                else
                begin
                    run_program(1'b0);
                end
            end
        end

        drain();
        $display("Run covered %0d commands and %0d results over %0d phases.",
                 n_items, n_results, N_PHASES);
        $display("Fallback lookups %0d, clamped loads %0d, loads into a full table %0d.",
                 n_fallback, n_clamp, n_full);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
